/* src/yuyv_to_bgr888_converter_core_assert.svh */
// Assertion macros used by the checker file.
`ifndef YUYV_TO_BGR888_CONVERTER_CORE_ASSERT_SVH
`define YUYV_TO_BGR888_CONVERTER_CORE_ASSERT_SVH

// Same-cycle implication, held off while in reset.
`define Y2B_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, held off while in reset.
`define Y2B_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* src/y2bgr_pkg.sv */
package y2bgr_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int DIM_W     = 13;   // config register width
    localparam int POS_W     = 12;   // row / column width
    localparam int PIX_W     = 8;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1280);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(720);
    localparam logic [DIM_W-1:0] WIDTH_LIMIT  = DIM_W'(MAX_WIDTH & ~1);
    localparam logic [DIM_W-1:0] HEIGHT_LIMIT = DIM_W'(MAX_HEIGHT);

    // Fixed point: 12 fraction bits, coefficients round(c * 4096)
    localparam int FRAC_BITS = 12;
    localparam int SUM_W     = 23;
    localparam logic signed [SUM_W-1:0] COEF_BU = SUM_W'(7250);
    localparam logic signed [SUM_W-1:0] COEF_GU = SUM_W'(1409);
    localparam logic signed [SUM_W-1:0] COEF_GV = SUM_W'(2925);
    localparam logic signed [SUM_W-1:0] COEF_RV = SUM_W'(5747);
    localparam logic [PIX_W-1:0] PIXEL_MAX = 8'd255;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [PIX_W-1:0] luma_first;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] luma_second;
        logic [PIX_W-1:0] chroma_red;
    } yuyv_t;

    typedef struct packed {
        logic [PIX_W-1:0] blue_first;
        logic [PIX_W-1:0] green_first;
        logic [PIX_W-1:0] red_first;
        logic [PIX_W-1:0] blue_second;
        logic [PIX_W-1:0] green_second;
        logic [PIX_W-1:0] red_second;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_column;
        logic             frame_last;
    } bgr_t;

    // One classified macropixel as it sits in the queue
    typedef struct packed {
        yuyv_t            pix;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] column;
        logic             last;
    } q_entry_t;

    // Floor by the fraction bits, then clamp to 0..255
    function automatic logic [PIX_W-1:0] clamp_pixel(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-FRAC_BITS-2:0] q;
        q = s[SUM_W-2:FRAC_BITS];
        if (s[SUM_W-1])
            return '0;
        else if (q > (SUM_W-FRAC_BITS-1)'(PIXEL_MAX))
            return PIXEL_MAX;
        else
            return q[PIX_W-1:0];
    endfunction

endpackage

/* src/y2bgr_front.sv */
module y2bgr_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [y2bgr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [y2bgr_pkg::DIM_W-1:0]   cfg_data,
    input  logic                          pix_valid,
    output logic                          pix_ready,
    input  y2bgr_pkg::yuyv_t              pix_data,
    output logic                          push_valid,
    input  logic                          push_ready,
    output y2bgr_pkg::q_entry_t           push_entry
);
    import y2bgr_pkg::*;

    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;

    logic [DIM_W-1:0] w_raw, eff_w, eff_h;
    logic [DIM_W-1:0] col_c, row_c;
    logic             line_end, frame_end, accept, cfg_hit;

    assign cfg_ready  = 1'b1;
    assign pix_ready  = push_ready;
    assign push_valid = pix_valid;
    assign accept     = pix_valid && push_ready;
    assign cfg_hit    = cfg_valid && (cfg_index == REG_FRAME_WIDTH ||
                                      cfg_index == REG_FRAME_HEIGHT);

    // effective frame size
    always_comb
    begin
        w_raw = {width_reg[DIM_W-1:1], 1'b0};
        priority if (w_raw < DIM_W'(2))
            eff_w = DIM_W'(2);
        else if (w_raw > WIDTH_LIMIT)
            eff_w = WIDTH_LIMIT;
        else
            eff_w = w_raw;
        priority if (height_reg == '0)
            eff_h = DIM_W'(1);
        else if (height_reg > HEIGHT_LIMIT)
            eff_h = HEIGHT_LIMIT;
        else
            eff_h = height_reg;
    end

    // position and line/frame end
    always_comb
    begin
        col_c     = ({1'b0, col_reg} >= eff_w) ? eff_w - DIM_W'(2) : {1'b0, col_reg};
        row_c     = ({1'b0, row_reg} >= eff_h) ? eff_h - DIM_W'(1) : {1'b0, row_reg};
        line_end  = (col_c + DIM_W'(2)) >= eff_w;
        frame_end = line_end && ((row_c + DIM_W'(1)) >= eff_h);

        push_entry.pix    = pix_data;
        push_entry.row    = POS_W'(eff_h - DIM_W'(1) - row_c);
        push_entry.column = col_c[POS_W-1:0];
        push_entry.last   = frame_end;
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_hit)
        begin
            if (cfg_index == REG_FRAME_WIDTH)
                width_next = cfg_data;
            else
                height_next = cfg_data;
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (!line_end)
            begin
                col_next = POS_W'(col_c + DIM_W'(2));
                row_next = row_c[POS_W-1:0];
            end
            else
            begin
                col_next = '0;
                row_next = frame_end ? '0 : POS_W'(row_c + DIM_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

/* src/y2bgr_queue.sv */
module y2bgr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  y2bgr_pkg::q_entry_t push_entry,
    output logic                pop_valid,
    input  logic                pop_ready,
    output y2bgr_pkg::q_entry_t pop_entry
);
    import y2bgr_pkg::*;

    q_entry_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  push, pop;

    assign push_ready = count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? QUEUE_AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? QUEUE_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

/* src/y2bgr_back.sv */
module y2bgr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  y2bgr_pkg::q_entry_t pop_entry,
    output logic                bgr_valid,
    input  logic                bgr_ready,
    output y2bgr_pkg::bgr_t     bgr_data
);
    import y2bgr_pkg::*;

    // stage 1: chroma products
    logic                    s1_valid_reg, s1_valid_next;
    q_entry_t                s1_meta_reg;
    logic signed [SUM_W-1:0] pb_reg, pgu_reg, pgv_reg, pr_reg;
    // stage 2: output register
    logic                    out_valid_reg, out_valid_next;
    bgr_t                    out_reg, out_next;

    logic                    s1_ready, s2_ready, s1_load, s2_load;
    logic signed [SUM_W-1:0] u_ext, v_ext, y1_ext, y2_ext, dg;

    assign s2_ready  = !out_valid_reg || bgr_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pop_ready = s1_ready;
    assign s1_load   = pop_valid && s1_ready;
    assign s2_load   = s1_valid_reg && s2_ready;
    assign bgr_valid = out_valid_reg;
    assign bgr_data  = out_reg;

    // offset-128 removal: flipping the msb gives the signed value
    assign u_ext = SUM_W'($signed({~pop_entry.pix.chroma_blue[PIX_W-1],
                                   pop_entry.pix.chroma_blue[PIX_W-2:0]}));
    assign v_ext = SUM_W'($signed({~pop_entry.pix.chroma_red[PIX_W-1],
                                   pop_entry.pix.chroma_red[PIX_W-2:0]}));

    always_comb
    begin
        y1_ext = $signed({(SUM_W-PIX_W-FRAC_BITS)'(0), s1_meta_reg.pix.luma_first,
                          FRAC_BITS'(0)});
        y2_ext = $signed({(SUM_W-PIX_W-FRAC_BITS)'(0), s1_meta_reg.pix.luma_second,
                          FRAC_BITS'(0)});
        dg     = -pgu_reg - pgv_reg;
        out_next.blue_first   = clamp_pixel(y1_ext + pb_reg);
        out_next.green_first  = clamp_pixel(y1_ext + dg);
        out_next.red_first    = clamp_pixel(y1_ext + pr_reg);
        out_next.blue_second  = clamp_pixel(y2_ext + pb_reg);
        out_next.green_second = clamp_pixel(y2_ext + dg);
        out_next.red_second   = clamp_pixel(y2_ext + pr_reg);
        out_next.out_row      = s1_meta_reg.row;
        out_next.out_column   = s1_meta_reg.column;
        out_next.frame_last   = s1_meta_reg.last;
    end

    always_comb
    begin
        s1_valid_next  = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_reg);
        out_valid_next = s2_load ? 1'b1 : (bgr_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_meta_reg <= pop_entry;
            pb_reg      <= u_ext * COEF_BU;
            pgu_reg     <= u_ext * COEF_GU;
            pgv_reg     <= v_ext * COEF_GV;
            pr_reg      <= v_ext * COEF_RV;
        end
        if (s2_load)
            out_reg <= out_next;
    end

endmodule

/* src/yuyv_to_bgr888_converter_core.sv */
// YUYV 4:2:2 to BGR888 converter with vertical flip. Each transfer on the pix
// channel is one macropixel (Y0, U, Y1, V); each transfer on the bgr channel is
// the matching pixel pair in blue, green, red byte order with its destination
// row (frame_height-1 minus the source line), its even start column and a flag
// on the last pair of the frame. Colors use 12-bit fixed point:
// B = Y + 1.770U', G = Y - 0.344U' - 0.714V', R = Y + 1.403V' with U' and V'
// offset by 128, floored and clamped to 0..255. Throughput is one macropixel
// per clock while bgr_ready does not stall the output. An accepted macropixel
// is written into the queue on the accepting edge, then registered in the product
// stage, then in the sum/clamp output register, where bgr_valid rises. The front
// end tracks row and column and classifies line/frame ends; a 4-entry queue
// separates it from the color pipeline so either side may stall on its own.
// Config registers: index 0 frame_width (low bit ignored, 2..4096), index 1
// frame_height (1..4096); any write to them restarts the frame. Writes to
// other indexes are ignored. cfg_ready is always high; write only while idle.
module yuyv_to_bgr888_converter_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [y2bgr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [y2bgr_pkg::DIM_W-1:0]   cfg_data,
    input  logic                          pix_valid,
    output logic                          pix_ready,
    input  y2bgr_pkg::yuyv_t              pix_data,
    output logic                          bgr_valid,
    input  logic                          bgr_ready,
    output y2bgr_pkg::bgr_t               bgr_data
);
    import y2bgr_pkg::*;

    // front -> queue
    logic     push_valid, push_ready;
    q_entry_t push_entry;
    // queue -> back
    logic     pop_valid, pop_ready;
    q_entry_t pop_entry;

    // Counters, frame size registers, line/frame end classification
    y2bgr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pix_data   (pix_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // Decoupling queue; pix_ready drops only when it is full
    y2bgr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // Two-stage color pipeline: registered products, then sums, floor, clamp
    y2bgr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .bgr_valid  (bgr_valid),
        .bgr_ready  (bgr_ready),
        .bgr_data   (bgr_data)
    );

endmodule

/* src/y2bgr_checker.sv */
`include "yuyv_to_bgr888_converter_core_assert.svh"

module y2bgr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [y2bgr_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [y2bgr_pkg::DIM_W-1:0]   cfg_data,
    input logic                          pix_valid,
    input logic                          pix_ready,
    input y2bgr_pkg::yuyv_t              pix_data,
    input logic                          bgr_valid,
    input logic                          bgr_ready,
    input y2bgr_pkg::bgr_t               bgr_data
);
    import y2bgr_pkg::*;

    // a stalled result holds
    `Y2B_ASSERT_NEXT(a_out_hold, clk, rst_n, bgr_valid && !bgr_ready, bgr_valid && $stable(bgr_data))
    // pairs always start on an even column
    `Y2B_ASSERT_IMPL(a_col_even, clk, rst_n, bgr_valid, !bgr_data.out_column[0])
    // the flipped frame ends on destination row zero
    `Y2B_ASSERT_IMPL(a_last_row, clk, rst_n, bgr_valid && bgr_data.frame_last, bgr_data.out_row == '0)
    // config channel never back-pressures
    `Y2B_ASSERT_IMPL(a_cfg_rdy, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind yuyv_to_bgr888_converter_core y2bgr_checker u_y2bgr_checker (.*);

/* sim/yuyv_to_bgr888_converter_core_tb.sv */
`timescale 1ns / 100ps

module yuyv_to_bgr888_converter_core_tb;
    import y2bgr_pkg::*;

    localparam int CLK_PERIOD_NS  = 8;
    localparam int RESET_CYCLES   = 9;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int TARGET_ITEMS   = 1300;
    localparam int SETTLE_CYCLES  = 24;    // idle wait after the final drain

    // Color math, 12 fraction bits
    localparam int FRACTION_BITS = 12;
    localparam int CHROMA_BIAS   = 128;
    localparam int BLUE_PER_U    = 7250;
    localparam int GREEN_PER_U   = 1409;
    localparam int GREEN_PER_V   = 2925;
    localparam int RED_PER_V     = 5747;
    localparam int CHANNEL_TOP   = 255;

    localparam logic [DIM_W-1:0] WIDTH_AT_RESET  = 13'd1280;
    localparam logic [DIM_W-1:0] HEIGHT_AT_RESET = 13'd720;

    // Highest index on the config bus; everything above frame_height is a hole
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST = '1;

    typedef enum int
    {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_TRICKLE,
        SINK_PERIODIC
    } sink_mode_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;
    logic                 pix_valid = 1'b0;
    logic                 pix_ready;
    yuyv_t                pix_data  = '0;
    logic                 bgr_valid;
    logic                 bgr_ready = 1'b0;
    bgr_t                 bgr_data;

    // Stimulus backlog and expected pixel pairs
    yuyv_t macropixel_backlog[$];
    bgr_t  expected_pairs[$];
    int    queued_count   = 0;
    int    accepted_count = 0;
    int    mismatch_count = 0;

    // Predictor copy of the geometry registers and the position counters
    logic [DIM_W-1:0] geom_width  = WIDTH_AT_RESET;
    logic [DIM_W-1:0] geom_height = HEIGHT_AT_RESET;
    int               col_next    = 0;
    int               row_next    = 0;

    // Sender burst pacing
    int gap_left   = 0;
    int burst_left = 0;

    // Receiver stall pattern
    sink_mode_t sink_mode = SINK_OPEN;
    int         sink_hold = 0;
    int         sink_tick = 0;

    bgr_t pair_due;

    yuyv_to_bgr888_converter_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data),
        .bgr_valid (bgr_valid),
        .bgr_ready (bgr_ready),
        .bgr_data  (bgr_data)
    );

    always #(CLK_PERIOD_NS / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Floor away the fraction, then pin to 0..255
    function automatic logic [PIX_W-1:0] clamp_channel(int sum);
        int whole;
        if (sum < 0)
            return '0;
        whole = sum >>> FRACTION_BITS;
        if (whole > CHANNEL_TOP)
            return PIX_W'(CHANNEL_TOP);
        return PIX_W'(whole);
    endfunction

    // Converts one macropixel and steps the row/column position
    function automatic bgr_t next_bgr_pair(yuyv_t px);
        bgr_t res;
        int   w;
        int   h;
        int   luma0;
        int   luma1;
        int   u;
        int   v;
        int   blue_delta;
        int   green_delta;
        int   red_delta;
        logic line_done;
        logic frame_done;

        // Low width bit is dropped; both dimensions saturate at the limits
        w = int'(geom_width & ~13'd1);
        if (w < 2)
            w = 2;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        h = int'(geom_height);
        if (h < 1)
            h = 1;
        if (h > MAX_HEIGHT)
            h = MAX_HEIGHT;

        if (col_next >= w)
            col_next = w - 2;
        if (row_next >= h)
            row_next = h - 1;
        line_done  = (col_next + 2 >= w);
        frame_done = line_done && (row_next + 1 >= h);

        luma0       = int'(px.luma_first) <<< FRACTION_BITS;
        luma1       = int'(px.luma_second) <<< FRACTION_BITS;
        u           = int'(px.chroma_blue) - CHROMA_BIAS;
        v           = int'(px.chroma_red) - CHROMA_BIAS;
        blue_delta  = BLUE_PER_U * u;
        green_delta = -GREEN_PER_U * u - GREEN_PER_V * v;
        red_delta   = RED_PER_V * v;

        res.blue_first   = clamp_channel(luma0 + blue_delta);
        res.green_first  = clamp_channel(luma0 + green_delta);
        res.red_first    = clamp_channel(luma0 + red_delta);
        res.blue_second  = clamp_channel(luma1 + blue_delta);
        res.green_second = clamp_channel(luma1 + green_delta);
        res.red_second   = clamp_channel(luma1 + red_delta);
        res.out_row      = POS_W'(h - 1 - row_next);   // vertical flip
        res.out_column   = POS_W'(col_next);
        res.frame_last   = frame_done;

        if (!line_done)
            col_next = col_next + 2;
        else
        begin
            col_next = 0;
            row_next = frame_done ? 0 : row_next + 1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic note_mismatch(string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(string name, logic [POS_W-1:0] got, logic [POS_W-1:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Byte with extra weight on both ends so the clamps get hit often
    function automatic logic [PIX_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_macropixel(logic [PIX_W-1:0] y0, logic [PIX_W-1:0] u,
                                    logic [PIX_W-1:0] y1, logic [PIX_W-1:0] v);
        yuyv_t px;
        px.luma_first  = y0;
        px.chroma_blue = u;
        px.luma_second = y1;
        px.chroma_red  = v;
        macropixel_backlog.push_back(px);
        queued_count++;
    endtask

    // One transfer on the config channel; the predictor follows on acceptance
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:
            begin
                geom_width = value;
                col_next   = 0;
                row_next   = 0;
            end
            REG_FRAME_HEIGHT:
            begin
                geom_height = value;
                col_next    = 0;
                row_next    = 0;
            end
            default:
            begin
            end
        endcase
    endtask

    // Hold the sender until every queued pair has come back
    task automatic wait_for_drain();
        while (accepted_count != queued_count || expected_pairs.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_frame_chunk(int count);
        repeat (count)
            queue_macropixel(rand_sample(), rand_sample(), rand_sample(), rand_sample());
        wait_for_drain();
    endtask

    task automatic set_geometry(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        write_register(REG_FRAME_WIDTH, w);
        write_register(REG_FRAME_HEIGHT, h);
    endtask

    // ------------------------------------------------------------------
    // Driver: macropixel transfers in bursts with random gaps
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_valid && pix_ready)
            begin
                expected_pairs.push_back(next_bgr_pair(pix_data));
                accepted_count++;
            end
            // Payload only moves once the previous transfer is done
            if (!pix_valid || pix_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    pix_valid <= 1'b0;
                end
                else if (macropixel_backlog.size() != 0)
                begin
                    pix_valid <= 1'b1;
                    pix_data  <= macropixel_backlog.pop_front();
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        // Now and then a long run with no gaps at all
                        if ($urandom_range(0, 7) == 0)
                        begin
                            burst_left = $urandom_range(40, 120);
                            gap_left   = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 24);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                        end
                    end
                end
                else
                    pix_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready follows a mode that is picked at random and held for a random time
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            sink_tick++;
            if (sink_hold == 0)
            begin
                sink_mode = sink_mode_t'($urandom_range(0, 3));
                sink_hold = $urandom_range(32, 300);
            end
            else
                sink_hold--;
            case (sink_mode)
                SINK_OPEN:     bgr_ready <= 1'b1;
                SINK_RANDOM:   bgr_ready <= ($urandom_range(0, 1) == 1);
                SINK_TRICKLE:  bgr_ready <= ($urandom_range(0, 3) == 0);  // backs up the queue
                SINK_PERIODIC: bgr_ready <= (sink_tick % 7) < 4;
                default:       bgr_ready <= 1'b1;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every pixel-pair transfer against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && bgr_valid && bgr_ready)
        begin
            if (expected_pairs.size() == 0)
                note_mismatch($sformatf("pair with nothing expected, row %0d col %0d",
                                        bgr_data.out_row, bgr_data.out_column));
            else
            begin
                pair_due = expected_pairs.pop_front();
                compare_field("blue_first", POS_W'(bgr_data.blue_first),
                              POS_W'(pair_due.blue_first));
                compare_field("green_first", POS_W'(bgr_data.green_first),
                              POS_W'(pair_due.green_first));
                compare_field("red_first", POS_W'(bgr_data.red_first),
                              POS_W'(pair_due.red_first));
                compare_field("blue_second", POS_W'(bgr_data.blue_second),
                              POS_W'(pair_due.blue_second));
                compare_field("green_second", POS_W'(bgr_data.green_second),
                              POS_W'(pair_due.green_second));
                compare_field("red_second", POS_W'(bgr_data.red_second),
                              POS_W'(pair_due.red_second));
                compare_field("out_row", bgr_data.out_row, pair_due.out_row);
                compare_field("out_column", bgr_data.out_column, pair_due.out_column);
                compare_field("frame_last", POS_W'(bgr_data.frame_last),
                              POS_W'(pair_due.frame_last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        int w;
        int h;
        int pick;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: every corner of the four bytes at the reset geometry
        for (int c = 0; c < 16; c++)
            queue_macropixel(c[3] ? 8'hFF : 8'h00, c[2] ? 8'hFF : 8'h00,
                             c[1] ? 8'hFF : 8'h00, c[0] ? 8'hFF : 8'h00);
        queue_macropixel(8'd128, 8'd128, 8'd128, 8'd128);  // neutral grey
        queue_macropixel(8'd0, 8'd128, 8'd255, 8'd128);    // black / white pair
        queue_macropixel(8'd81, 8'd90, 8'd145, 8'd240);    // strong red
        queue_macropixel(8'd41, 8'd240, 8'd41, 8'd110);    // strong blue
        queue_macropixel(8'd0, 8'd129, 8'd1, 8'd127);      // small negative sums
        queue_macropixel(8'd255, 8'd127, 8'd254, 8'd129);  // just past the top
        wait_for_drain();

        // Width below two and height zero: every pair ends a frame; then small frames
        set_geometry(13'd0, 13'd0);
        run_frame_chunk(30);
        set_geometry(13'd1, 13'd3);
        run_frame_chunk(30);
        set_geometry(13'd6, 13'd4);
        run_frame_chunk(120);
        // Odd width behaves as the even one below it
        set_geometry(13'd7, 13'd5);
        run_frame_chunk(100);
        // Hole in the register map: counters must carry on mid-frame
        write_register(REG_SPARE_LAST, 13'h1FFF);
        run_frame_chunk(50);
        // Widest and tallest frames, only partly walked
        set_geometry(13'd4096, 13'd2);
        run_frame_chunk(60);
        set_geometry(13'h1FFF, 13'h1FFF);
        run_frame_chunk(40);
        set_geometry(13'd2, 13'd4096);
        run_frame_chunk(50);
        set_geometry(13'd5000, 13'd4097);
        run_frame_chunk(40);

        // Random geometry, mostly small frames so frame ends come often
        while (queued_count < TARGET_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            w = (pick < 7) ? $urandom_range(0, 40) :
                (pick < 9) ? $urandom_range(41, 600) : $urandom_range(4090, 8191);
            h = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12) : $urandom_range(4090, 8191);
            case ($urandom_range(0, 5))
                0: write_register(REG_FRAME_WIDTH, DIM_W'(w));
                1: write_register(REG_FRAME_HEIGHT, DIM_W'(h));
                2: write_register(CFG_IDX_W'($urandom_range(int'(REG_FRAME_HEIGHT) + 1,
                                                            int'(REG_SPARE_LAST))),
                                  DIM_W'($urandom_range(0, 8191)));
                default: set_geometry(DIM_W'(w), DIM_W'(h));
            endcase
            run_frame_chunk($urandom_range(30, 120));
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);   // catch any stray late pair

        if (mismatch_count == 0 && expected_pairs.size() == 0)
            $display("yuyv_to_bgr888_converter_core test passed");
        else
            $display("yuyv_to_bgr888_converter_core test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(CLK_PERIOD_NS * TIMEOUT_CYCLES);
        $display("[%0t] timeout, %0d pairs still expected", $time, expected_pairs.size());
        $display("yuyv_to_bgr888_converter_core test failed");
        $finish;
    end

endmodule
